// ===== design/sacn_pkg.sv =====
// Shared types and constants for the set-associative NRU cache lookup block.
package sacn_pkg;

	// Fixed field widths of the stream and configuration ports
	localparam int ADDR_IN_W  = 32;
	localparam int TAG_W      = 32;
	localparam int WAY_OUT_W  = 3;
	localparam int MISS_W     = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int IDX_RAW_W  = 7;
	localparam int OUT_DATA_W = 40;

	// Register reset values
	localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
	localparam logic [2:0] INDEX_BITS_RST  = 3'd6;
	localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

	// Register indexes, taken from the word address
	typedef enum logic [1:0] {
		REG_OFFSET_BITS = 2'd0,
		REG_INDEX_BITS  = 2'd1,
		REG_WAYS_IN_USE = 2'd2
	} reg_idx_t;

	// Configuration handed to the front end
	typedef struct packed {
		logic [4:0] offset_bits;
		logic [2:0] index_bits;
		logic [3:0] ways_in_use;
	} cfg_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_LOOK
	} back_state_t;

endpackage

// ===== design/sacn_front.sv =====
// Front end: splits an address into tag and set and builds the way mask.
module sacn_front #(
	parameter int SETS       = 64,
	parameter int WAYS       = 8,
	parameter int ADDR_WIDTH = 32,
	parameter int SET_W      = 6,
	parameter int ITEM_W     = 46
) (
	input  sacn_pkg::cfg_t                    cfg,
	input  logic [sacn_pkg::ADDR_IN_W-1:0]    address,
	output logic [ITEM_W-1:0]                 item
);

	localparam int RAW_N = 1 << sacn_pkg::IDX_RAW_W;

	typedef logic [RAW_N-1:0][SET_W-1:0] set_tab_t;

	// Fold the raw index into the set range, worked out at elaboration
	function automatic set_tab_t mk_set_tab();
		set_tab_t t;
		for (int i = 0; i < RAW_N; i++) begin
			t[i] = SET_W'(i % SETS);
		end
		return t;
	endfunction

	localparam set_tab_t SET_TAB = mk_set_tab();

	localparam logic [sacn_pkg::ADDR_IN_W-1:0] AMASK = (ADDR_WIDTH >= sacn_pkg::ADDR_IN_W) ?
		{sacn_pkg::ADDR_IN_W{1'b1}} :
		sacn_pkg::ADDR_IN_W'((64'd1 << ADDR_WIDTH) - 64'd1);

	logic [sacn_pkg::ADDR_IN_W-1:0] addr_m;
	logic [sacn_pkg::TAG_W-1:0]     shifted;
	logic [sacn_pkg::IDX_RAW_W-1:0] idx_mask;
	logic [sacn_pkg::IDX_RAW_W-1:0] idx_raw;
	logic [SET_W-1:0]               set_idx;
	logic [4:0]                     nways;
	logic [WAYS-1:0]                way_mask;

	// Classify the address: tag, set and ways that take part
	always_comb begin
		addr_m   = address & AMASK;
		shifted  = addr_m >> cfg.offset_bits;
		idx_mask = sacn_pkg::IDX_RAW_W'((8'd1 << cfg.index_bits) - 8'd1);
		idx_raw  = shifted[sacn_pkg::IDX_RAW_W-1:0] & idx_mask;
		set_idx  = SET_TAB[idx_raw];

		nways = {1'b0, cfg.ways_in_use};
		if (nways == 5'd0) begin
			nways = 5'd1;
		end
		if (nways > 5'(WAYS)) begin
			nways = 5'(WAYS);
		end
		for (int w = 0; w < WAYS; w++) begin
			way_mask[w] = (5'(w) < nways);
		end

		item = {way_mask, set_idx, shifted};
	end

endmodule

// ===== design/sacn_fifo.sv =====
// Two-entry queue between the front end and the lookup back end.
module sacn_fifo #(
	parameter int WIDTH = 46
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [1:0][WIDTH-1:0] slot_q;
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/sacn_back.sv =====
// Back end: reads a set's tags, matches, picks the NRU victim and updates state.
module sacn_back #(
	parameter int SETS   = 64,
	parameter int WAYS   = 8,
	parameter int SET_W  = 6,
	parameter int ITEM_W = 46
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  logic [ITEM_W-1:0]               q_item,
	output logic                            q_pop,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            out_hit,
	output logic [sacn_pkg::WAY_OUT_W-1:0]  out_way,
	output logic [sacn_pkg::MISS_W-1:0]     out_miss
);

	localparam int TW     = sacn_pkg::TAG_W;
	localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W  = WAYS * TW;
	localparam int FLAG_W = 2 * WAYS;
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

	// Lowest set bit of a way vector
	function automatic logic [WIDX_W-1:0] lowest(input logic [WAYS-1:0] v);
		logic [WIDX_W-1:0] r;
		r = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = WIDX_W'(i);
			end
		end
		return r;
	endfunction

	sacn_pkg::back_state_t state_q, state_d;

	logic [ROW_W-1:0]          tag_mem [SETS];
	logic [FLAG_W-1:0]         flag_mem [SETS];
	logic [ROW_W-1:0]          row_s1;
	logic [FLAG_W-1:0]         flags_s1;
	logic [TW-1:0]             tag_s1;
	logic [SET_W-1:0]          set_s1;
	logic [WAYS-1:0]           mask_s1;

	logic [SET_W-1:0]          clr_q;
	logic                      clr_go;
	logic [sacn_pkg::MISS_W-1:0] cnt_q;

	logic                          out_valid_q;
	logic                          hit_q;
	logic [sacn_pkg::WAY_OUT_W-1:0] way_q;
	logic [sacn_pkg::MISS_W-1:0]   miss_q;

	logic [TW-1:0]     q_tag;
	logic [SET_W-1:0]  q_set;
	logic [WAYS-1:0]   q_mask;
	logic              look;

	logic [WAYS-1:0]   vrow, rrow, hitv, inv, rbase, sel_oh, new_ref, new_valid;
	logic              all_ref, is_hit;
	logic [WIDX_W-1:0] victim, sel;
	logic [ROW_W-1:0]  wr_row;
	logic [sacn_pkg::MISS_W-1:0] cnt_next;
	logic [WIDX_W+sacn_pkg::WAY_OUT_W-1:0] way_ext;

	assign q_tag  = q_item[TW-1:0];
	assign q_set  = q_item[TW +: SET_W];
	assign q_mask = q_item[TW+SET_W +: WAYS];

	assign out_valid = out_valid_q;
	assign out_hit   = hit_q;
	assign out_way   = way_q;
	assign out_miss  = miss_q;

	// Sequence: clear the flags after reset, then take an item when the
	// output slot is free and evaluate it
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		look    = 1'b0;
		clr_go  = 1'b0;
		case (state_q)
			sacn_pkg::B_CLEAR: begin
				clr_go = 1'b1;
				if (clr_q == LAST_SET) begin
					state_d = sacn_pkg::B_IDLE;
				end
			end
			sacn_pkg::B_IDLE: begin
				if (q_valid && (!out_valid_q || out_ready)) begin
					q_pop   = 1'b1;
					state_d = sacn_pkg::B_LOOK;
				end
			end
			sacn_pkg::B_LOOK: begin
				look    = 1'b1;
				state_d = sacn_pkg::B_IDLE;
			end
			default: begin
				state_d = sacn_pkg::B_IDLE;
			end
		endcase
	end

	// Match the ways and choose the victim
	always_comb begin
		vrow = flags_s1[WAYS-1:0];
		rrow = flags_s1[WAYS +: WAYS];
		for (int w = 0; w < WAYS; w++) begin
			hitv[w] = vrow[w] & mask_s1[w] & (row_s1[w*TW +: TW] == tag_s1);
		end
		is_hit  = |hitv;
		inv     = ~vrow & mask_s1;
		all_ref = ((rrow & mask_s1) == mask_s1);
		rbase   = all_ref ? (rrow & ~mask_s1) : rrow;
		victim  = (|inv) ? lowest(inv) : lowest(~rbase & mask_s1);
		sel     = is_hit ? lowest(hitv) : victim;
		sel_oh  = WAYS'(1) << sel;
		new_ref   = (is_hit ? rrow : rbase) | sel_oh;
		new_valid = vrow | sel_oh;
		for (int w = 0; w < WAYS; w++) begin
			wr_row[w*TW +: TW] = sel_oh[w] ? tag_s1 : row_s1[w*TW +: TW];
		end
		cnt_next = (cnt_q != {sacn_pkg::MISS_W{1'b1}}) ? cnt_q + 1'b1 : cnt_q;
		way_ext  = {{sacn_pkg::WAY_OUT_W{1'b0}}, sel};
	end

	// Hold state, clear pointer, counter and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacn_pkg::B_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_go) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (look) begin
				if (!is_hit) begin
					cnt_q <= cnt_next;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Tag and flag memories and lookup payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			row_s1   <= tag_mem[q_set];
			flags_s1 <= flag_mem[q_set];
			tag_s1   <= q_tag;
			set_s1   <= q_set;
			mask_s1  <= q_mask;
		end
		if (clr_go) begin
			flag_mem[clr_q] <= '0;
		end else if (look) begin
			flag_mem[set_s1] <= {new_ref, new_valid};
		end
		if (look && !is_hit) begin
			tag_mem[set_s1] <= wr_row;
		end
		if (look) begin
			hit_q  <= is_hit;
			way_q  <= way_ext[sacn_pkg::WAY_OUT_W-1:0];
			miss_q <= is_hit ? cnt_q : cnt_next;
		end
	end

endmodule

// ===== design/set_assoc_cache_nru_lookup_core.sv =====
// Top level of the set-associative cache lookup with NRU replacement.
//
// Addresses arrive on the s_axis channel, one per transaction. Each one is
// looked up in a cache of SETS sets by WAYS ways; one result per address
// leaves on the m_axis channel in arrival order: hit flag, way, and the
// saturating miss count since reset.
// Each address passes through the queue, the lookup's row registers and
// the output register. The lookup sequencer takes one address at a time:
// it reads a set's tag and flag rows into registers, then compares,
// selects and writes back before it takes the next address.
// A two-entry queue sits between the address front end and the lookup;
// s_tready falls only when that queue is full. When the receiver stalls the
// result holds in the output register, the lookup waits, and addresses keep
// being taken until the queue fills.
// Registers (APB, byte address 4*i): offset_bits, index_bits, ways_in_use.
// Write them only while no transaction is in flight.
// Reset clears the miss count and the registers (offset 4, index 6, ways 8),
// then a pass over all SETS sets (64 by default) clears valid and reference
// bits; addresses queue meanwhile but no lookup runs. Tags are not cleared.
module set_assoc_cache_nru_lookup_core #(
	parameter int SETS       = 64,
	parameter int WAYS       = 8,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sacn_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [sacn_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [sacn_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	// Address stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sacn_pkg::ADDR_IN_W-1:0]    s_tdata,  // [31:0] address
	// Result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sacn_pkg::OUT_DATA_W-1:0]   m_tdata   // [0] hit, [3:1] way, [35:4] miss_total
);

	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int ITEM_W = sacn_pkg::TAG_W + SET_W + WAYS;

	sacn_pkg::cfg_t cfg_q;
	sacn_pkg::reg_idx_t reg_sel;

	logic [ITEM_W-1:0] f_item, q_item;
	logic              q_full, q_valid, q_pop, s_acc;
	logic              r_hit;
	logic [sacn_pkg::WAY_OUT_W-1:0] r_way;
	logic [sacn_pkg::MISS_W-1:0]    r_miss;

	assign pready  = 1'b1;
	assign reg_sel = sacn_pkg::reg_idx_t'(paddr[3:2]);

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits <= sacn_pkg::OFFSET_BITS_RST;
			cfg_q.index_bits  <= sacn_pkg::INDEX_BITS_RST;
			cfg_q.ways_in_use <= sacn_pkg::WAYS_IN_USE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				sacn_pkg::REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[4:0];
				sacn_pkg::REG_INDEX_BITS:  cfg_q.index_bits  <= pwdata[2:0];
				sacn_pkg::REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// Read back registers
	always_comb begin
		case (reg_sel)
			sacn_pkg::REG_OFFSET_BITS: prdata = {27'd0, cfg_q.offset_bits};
			sacn_pkg::REG_INDEX_BITS:  prdata = {29'd0, cfg_q.index_bits};
			sacn_pkg::REG_WAYS_IN_USE: prdata = {28'd0, cfg_q.ways_in_use};
			default:                   prdata = '0;
		endcase
	end

	assign s_tready = !q_full;
	assign s_acc    = s_tvalid && !q_full;

	sacn_front #(
		.SETS       (SETS),
		.WAYS       (WAYS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.SET_W      (SET_W),
		.ITEM_W     (ITEM_W)
	) u_front (
		.cfg     (cfg_q),
		.address (s_tdata),
		.item    (f_item)
	);

	sacn_fifo #(
		.WIDTH (ITEM_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_acc),
		.push_data (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_item)
	);

	sacn_back #(
		.SETS   (SETS),
		.WAYS   (WAYS),
		.SET_W  (SET_W),
		.ITEM_W (ITEM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_hit   (r_hit),
		.out_way   (r_way),
		.out_miss  (r_miss)
	);

	assign m_tdata = {4'd0, r_miss, r_way, r_hit};

endmodule
